// ----- rtl/spr_pkg.sv -----
package spr_pkg;

    localparam int PATTERN_MAX = 32;
    localparam int SAVE_DEPTH  = 32;
    localparam int PAT_AW      = $clog2(PATTERN_MAX);
    localparam int SAVE_AW     = $clog2(SAVE_DEPTH);
    localparam int PTR_W       = SAVE_AW + 1;
    localparam int LEN_W       = 6;
    localparam int CNT_W       = 16;
    localparam int MAX_RESULTS = 64;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS) + 1;

    localparam logic [7:0]       SLASH_CH  = 8'h2F;
    localparam logic [7:0]       NUL_CH    = 8'h00;
    localparam logic [LEN_W-1:0] EAT_LIMIT = LEN_W'(62);
    localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

    // Request function codes.
    localparam logic [1:0] FN_DATA      = 2'd0;
    localparam logic [1:0] FN_EOS       = 2'd1;
    localparam logic [1:0] FN_LOAD_FROM = 2'd2;
    localparam logic [1:0] FN_LOAD_TO   = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_DATA     = 2'd0;
    localparam logic [1:0] ST_SHORT    = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;
    localparam logic [1:0] ST_DONE     = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] CFG_FROM_LEN = 3'd0;
    localparam logic [2:0] CFG_TO_LEN   = 3'd1;
    localparam logic [2:0] CFG_REV      = 3'd2;
    localparam logic [2:0] CFG_COLLAPSE = 3'd3;
    localparam logic [2:0] CFG_SAFE     = 3'd4;

    typedef struct packed {
        logic [7:0]       data;
        logic             bvalid;
        logic [1:0]       status;
        logic [CNT_W-1:0] count;
        logic             err;
    } t_res;

    typedef struct packed {
        logic push;
        logic flush;
        t_res res;
    } t_ostg_req;

    typedef struct packed {
        logic can_push;
        logic flush_done;
    } t_ostg_ack;

endpackage

// ----- rtl/slash_padded_path_replacer.sv -----
// Byte stream filter that replaces each occurrence of a loaded search path with a loaded
// replacement path, keeping the stream length by consuming or emitting padding slashes.
// Requests are handled one at a time by a small sequencer around three single-port
// 32-byte memories (search path, replacement path and save buffer); it produces at most
// one result per cycle. A plain data byte in the scanning state passes through the
// accepting step, the reads of the pattern tails, a fetch and an execute step, and the
// hand-over of the final result; a pattern load goes from acceptance straight to the
// hand-over. Replaying a saved byte adds a fetch and an execute step, a save-buffer
// realignment a read and a write per byte moved, each replacement byte a read and an
// output step, and each padding slash written back a step of its own; a save overflow
// adds a read and an output step per buffered byte. Results wait in a holding register
// and an output register, so the downstream side may stall at any time without losing
// data; a stall lengthens the request while the sequencer waits for room.
module slash_padded_path_replacer
    import spr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [1:0]       i_func,
    input  logic [7:0]       i_data_byte,
    input  logic [4:0]       i_pattern_index,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [7:0]       o_out_byte,
    output logic             o_byte_valid,
    output logic [1:0]       o_status,
    output logic [CNT_W-1:0] o_replace_count,
    output logic             o_error_flag,
    output logic             o_last,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [2:0]       i_cfg_index,
    input  logic [LEN_W-1:0] i_cfg_data
);

    logic [LEN_W-1:0] r_from_len, r_to_len;
    logic             r_rev, r_collapse, r_safe;
    logic             idle;
    logic             in_acc;
    t_ostg_req        req;
    t_ostg_ack        ack;
    t_res             res;

    // Configuration is always accepted; writes beyond the register list are ignored.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_from_len <= LEN_W'(1);
            r_to_len   <= LEN_W'(1);
            r_rev      <= 1'b0;
            r_collapse <= 1'b0;
            r_safe     <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FROM_LEN: r_from_len <= i_cfg_data;
                CFG_TO_LEN:   r_to_len   <= i_cfg_data;
                CFG_REV:      r_rev      <= i_cfg_data[0];
                CFG_COLLAPSE: r_collapse <= i_cfg_data[0];
                CFG_SAFE:     r_safe     <= i_cfg_data[0];
                default:      ;
            endcase
        end
    end

    // A new request is taken only when the sequencer has finished the previous one and
    // the output side has room, since a pass-through byte is handed over at once.
    assign o_in_ready = idle && ack.can_push;
    assign in_acc     = i_in_valid && o_in_ready;

    spr_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_acc),
        .i_func     (i_func),
        .i_byte     (i_data_byte),
        .i_idx      (i_pattern_index),
        .i_from_len (r_from_len),
        .i_to_len   (r_to_len),
        .i_rev      (r_rev),
        .i_collapse (r_collapse),
        .i_safe     (r_safe),
        .i_ack      (ack),
        .o_req      (req),
        .o_idle     (idle)
    );

    spr_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_ack   (ack),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (res),
        .o_last  (o_last)
    );

    assign o_out_byte      = res.data;
    assign o_byte_valid    = res.bvalid;
    assign o_status        = res.status;
    assign o_replace_count = res.count;
    assign o_error_flag    = res.err;

    // A pattern load never produces a result.
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_func == FN_LOAD_FROM || i_func == FN_LOAD_TO) && !o_out_valid)
        |=> !o_out_valid)
        else $error("pattern load produced a result");

    // Status results carry no stream byte.
    a_status_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_DATA) |-> (!o_byte_valid && o_out_byte == NUL_CH))
        else $error("status result carries a byte");

    // Data results always carry a stream byte.
    a_data_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_DATA) |-> o_byte_valid)
        else $error("data result without byte");

endmodule

// ----- rtl/spr_out_stage.sv -----
module spr_out_stage
    import spr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_ostg_req i_req,
    output t_ostg_ack o_ack,
    output logic      o_valid,
    input  logic      i_ready,
    output t_res      o_res,
    output logic      o_last
);

    logic                 r_pend_v;
    t_res                 r_pend;
    logic                 r_out_v;
    t_res                 r_out;
    logic                 r_last;
    logic [RES_CNT_W-1:0] r_cnt;
    logic                 out_free;
    logic                 move;
    logic                 keep;

    // The newest result is held back one step so that the final one of a request
    // can be marked when the request ends.
    assign out_free = !r_out_v || i_ready;
    assign o_ack.can_push   = !r_pend_v || out_free;
    assign o_ack.flush_done = !r_pend_v || out_free;
    assign keep = i_req.push && (r_cnt < RES_CNT_W'(MAX_RESULTS));
    assign move = r_pend_v && out_free && ((i_req.push && keep) || i_req.flush);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (move) begin
                r_out_v <= 1'b1;
                r_out   <= r_pend;
                r_last  <= i_req.flush;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
            if (i_req.flush && o_ack.flush_done) begin
                r_pend_v <= 1'b0;
                r_cnt    <= '0;
            end else if (keep && o_ack.can_push) begin
                r_pend_v <= 1'b1;
                r_pend   <= i_req.res;
                r_cnt    <= r_cnt + 1'b1;
            end
        end
    end

    assign o_valid = r_out_v;
    assign o_res   = r_out;
    assign o_last  = r_last;

endmodule

// ----- rtl/spr_engine.sv -----
module spr_engine
    import spr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [1:0]       i_func,
    input  logic [7:0]       i_byte,
    input  logic [4:0]       i_idx,
    input  logic [LEN_W-1:0] i_from_len,
    input  logic [LEN_W-1:0] i_to_len,
    input  logic             i_rev,
    input  logic             i_collapse,
    input  logic             i_safe,
    input  t_ostg_ack        i_ack,
    output t_ostg_req        o_req,
    output logic             o_idle
);

    localparam logic [4:0] S_IDLE = 5'd0,  S_PRE = 5'd1,   S_PRE2 = 5'd2,  S_FETCH = 5'd3;
    localparam logic [4:0] S_EXEC = 5'd4,  S_MV_RD = 5'd5, S_MV_WR = 5'd6, S_CHK = 5'd7;
    localparam logic [4:0] S_COMP = 5'd8,  S_REP_RD = 5'd9, S_REP_OUT = 5'd10, S_POST = 5'd11;
    localparam logic [4:0] S_NUL0 = 5'd12, S_NULS = 5'd13, S_SHORT = 5'd14, S_MM = 5'd15;
    localparam logic [4:0] S_MM2 = 5'd16,  S_OVF = 5'd17,  S_OV_RD = 5'd18, S_OV_OUT = 5'd19;
    localparam logic [4:0] S_OV_C = 5'd20, S_EOFST = 5'd21, S_CLR = 5'd22, S_END = 5'd23;

    localparam logic [2:0] PH_SCAN = 3'd0, PH_MATCH = 3'd1, PH_PAD = 3'd2;
    localparam logic [2:0] PH_FIRST = 3'd3, PH_EAT = 3'd4, PH_COPY = 3'd5;

    logic [7:0] m_search  [PATTERN_MAX];
    logic [7:0] m_replace [PATTERN_MAX];
    logic [7:0] m_save    [SAVE_DEPTH];

    logic [4:0]       r_st, n_st;
    logic [2:0]       r_phase, n_phase;
    logic [PTR_W-1:0] r_rp, n_rp, r_ep, n_ep, r_k, n_k, r_cnt, n_cnt;
    logic [SAVE_AW-1:0] r_dst, n_dst;
    logic [LEN_W-1:0] r_mp, n_mp, r_eaten, n_eaten;
    logic [6:0]       r_pend, n_pend;
    logic             r_nul, n_nul, r_pass, n_pass, r_serr, n_serr;
    logic             r_have, n_have, r_eof, n_eof, r_saved, n_saved;
    logic             r_rlast, n_rlast, r_minx, n_minx;
    logic [CNT_W-1:0] r_repl, n_repl;
    logic [7:0]       r_fresh, n_fresh, r_spcur, n_spcur;
    logic [7:0]       r_sp_rd, r_rp_rd, r_sb_rd;

    logic               sp_we, rp_we, sb_we, sp_re, rp_re, sb_re;
    logic [PAT_AW-1:0]  pat_waddr, sp_raddr, rp_raddr;
    logic [SAVE_AW-1:0] sb_waddr, sb_raddr;
    logic [7:0]         sb_wdata;
    logic               push, flush, adv;
    logic [7:0]         p_data;
    logic               p_bv;
    logic [1:0]         p_st;
    logic [LEN_W-1:0]   fl, tl, nx;
    logic [7:0]         c;
    logic [PTR_W-1:0]   rem;
    logic [6:0]         pd;
    logic               rl, sl;

    assign fl = (i_from_len == '0) ? LEN_W'(1) :
                (i_from_len > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : i_from_len;
    assign tl = (i_to_len == '0) ? LEN_W'(1) :
                (i_to_len > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : i_to_len;
    assign nx  = r_mp + 1'b1;
    assign c   = r_saved ? r_sb_rd : r_fresh;
    assign rem = r_ep - r_rp;
    assign rl  = (r_rp_rd == SLASH_CH);
    assign sl  = (r_sp_rd == SLASH_CH);

    always_comb begin
        n_st = r_st; n_phase = r_phase; n_rp = r_rp; n_ep = r_ep; n_k = r_k;
        n_cnt = r_cnt; n_dst = r_dst; n_mp = r_mp; n_eaten = r_eaten; n_pend = r_pend;
        n_nul = r_nul; n_pass = r_pass; n_serr = r_serr; n_have = r_have; n_eof = r_eof;
        n_saved = r_saved; n_rlast = r_rlast; n_minx = r_minx; n_repl = r_repl;
        n_fresh = r_fresh; n_spcur = r_spcur;
        sp_we = 1'b0; rp_we = 1'b0; sb_we = 1'b0; sp_re = 1'b0; rp_re = 1'b0; sb_re = 1'b0;
        pat_waddr = PAT_AW'(i_idx); sp_raddr = '0; rp_raddr = '0;
        sb_waddr = '0; sb_raddr = '0; sb_wdata = c;
        push = 1'b0; flush = 1'b0; p_data = c; p_bv = 1'b1; p_st = ST_DATA;
        pd = '0;
        case (r_st)
            S_IDLE: begin
                if (i_start) begin
                    n_fresh = i_byte;
                    case (i_func)
                        FN_DATA: begin
                            if (r_pass) begin
                                push = 1'b1; p_data = i_byte; n_st = S_END;
                            end else begin
                                n_have = 1'b1; n_eof = 1'b0; n_st = S_PRE;
                            end
                        end
                        FN_EOS: begin
                            n_have = 1'b0;
                            if (r_pass) begin
                                n_st = S_EOFST;
                            end else begin
                                n_eof = 1'b1; n_st = S_PRE;
                            end
                        end
                        FN_LOAD_FROM: begin
                            sp_we = 1'b1; n_st = S_END;
                        end
                        default: begin
                            rp_we = 1'b1; n_st = S_END;
                        end
                    endcase
                end
            end
            S_PRE: begin
                rp_re = 1'b1; rp_raddr = PAT_AW'(tl - 1'b1);
                sp_re = 1'b1; sp_raddr = PAT_AW'(fl - 1'b1);
                n_st = S_PRE2;
            end
            S_PRE2: begin
                n_rlast = rl;
                n_minx  = ((tl > fl) && !rl) || (i_rev && (tl != fl) && !(sl && rl));
                n_st    = S_FETCH;
            end
            S_FETCH: begin
                sp_re = 1'b1;
                sp_raddr = (r_phase == PH_MATCH) ? PAT_AW'(nx) : '0;
                if (r_rp < r_ep) begin
                    sb_re = 1'b1; sb_raddr = r_rp[SAVE_AW-1:0];
                    n_rp = r_rp + 1'b1; n_saved = 1'b1; n_st = S_EXEC;
                end else if (r_have) begin
                    n_have = 1'b0; n_saved = 1'b0; n_st = S_EXEC;
                    if (r_phase == PH_MATCH || r_phase == PH_PAD) begin
                        if (r_ep >= PTR_W'(SAVE_DEPTH)) begin
                            n_st = S_OVF;
                        end else begin
                            sb_we = 1'b1; sb_waddr = r_ep[SAVE_AW-1:0]; sb_wdata = r_fresh;
                            n_ep = r_ep + 1'b1; n_rp = r_ep + 1'b1;
                        end
                    end
                end else if (r_eof && r_phase == PH_MATCH) begin
                    n_st = S_MM;
                end else if (r_eof && r_phase == PH_PAD) begin
                    n_st = S_SHORT;
                end else begin
                    n_st = r_eof ? S_EOFST : S_END;
                end
            end
            S_EXEC: begin
                n_st = S_FETCH;
                case (r_phase)
                    PH_SCAN: begin
                        if (c == NUL_CH) n_nul = 1'b1;
                        if (c != r_sp_rd) begin
                            push = 1'b1;
                            if (r_rp >= r_ep) begin
                                n_rp = '0; n_ep = '0;
                            end
                        end else begin
                            sb_we = 1'b1; sb_waddr = '0;
                            n_mp = '0; n_spcur = r_sp_rd; n_rp = PTR_W'(1);
                            if (r_saved && rem != '0) begin
                                n_k = r_rp; n_dst = SAVE_AW'(1); n_cnt = rem;
                                n_ep = rem + 1'b1; n_st = S_MV_RD;
                            end else begin
                                n_ep = PTR_W'(1); n_st = S_CHK;
                            end
                        end
                    end
                    PH_MATCH: begin
                        if (nx >= fl) begin
                            n_st = S_MM;
                        end else if (c == r_sp_rd) begin
                            n_mp = nx; n_spcur = r_sp_rd; n_st = S_CHK;
                        end else if (!(!i_rev && c == SLASH_CH && r_spcur == SLASH_CH)) begin
                            n_st = S_MM;
                        end
                    end
                    PH_PAD: begin
                        if (c == SLASH_CH) begin
                            pd = (r_pend != '0) ? r_pend - 1'b1 : '0;
                            n_pend = pd;
                            if (pd == '0) n_st = S_COMP;
                        end else begin
                            n_st = S_SHORT;
                        end
                    end
                    PH_FIRST, PH_EAT: begin
                        if (c == SLASH_CH) begin
                            if (r_phase == PH_FIRST) begin
                                push = 1'b1; n_phase = PH_EAT;
                            end else if (r_eaten < EAT_LIMIT) begin
                                n_eaten = r_eaten + 1'b1;
                            end
                        end else if (r_nul) begin
                            if (c == NUL_CH) begin
                                n_st = S_NUL0;
                            end else begin
                                push = 1'b1; n_phase = PH_COPY;
                            end
                        end else begin
                            sb_we = 1'b1; sb_waddr = '0;
                            n_rp = '0; n_ep = PTR_W'(1); n_phase = PH_SCAN;
                        end
                    end
                    default: begin
                        if (c == NUL_CH) n_st = S_NUL0;
                        else push = 1'b1;
                    end
                endcase
            end
            S_MV_RD: begin
                sb_re = 1'b1; sb_raddr = r_k[SAVE_AW-1:0]; n_st = S_MV_WR;
            end
            S_MV_WR: begin
                sb_we = 1'b1; sb_waddr = r_dst; sb_wdata = r_sb_rd;
                n_k = r_k + 1'b1; n_dst = r_dst + 1'b1; n_cnt = r_cnt - 1'b1;
                n_st = (r_cnt == PTR_W'(1)) ? S_CHK : S_MV_RD;
            end
            S_CHK: begin
                n_st = S_FETCH;
                if (nx >= fl) begin
                    pd = (7'(tl) > 7'(r_rp)) ? 7'(tl) - 7'(r_rp) + 7'(r_minx) : 7'(r_minx);
                    n_pend = pd;
                    if (pd == '0) n_st = S_COMP;
                    else n_phase = PH_PAD;
                end else begin
                    n_phase = PH_MATCH;
                end
            end
            S_COMP: begin
                if (r_repl != CNT_MAX) n_repl = r_repl + 1'b1;
                n_eaten = (LEN_W'(r_rp) >= tl) ? LEN_W'(r_rp) - tl : '0;
                n_rp = '0; n_ep = '0; n_k = '0; n_st = S_REP_RD;
            end
            S_REP_RD: begin
                rp_re = 1'b1; rp_raddr = PAT_AW'(r_k); n_st = S_REP_OUT;
            end
            S_REP_OUT: begin
                push = 1'b1; p_data = r_rp_rd; n_k = r_k + 1'b1;
                n_st = (LEN_W'(r_k) + 1'b1 == tl) ? S_POST : S_REP_RD;
            end
            S_POST: begin
                p_data = SLASH_CH;
                if (!i_collapse) begin
                    if (r_eaten != '0) begin
                        push = 1'b1; n_eaten = r_eaten - 1'b1;
                    end else begin
                        n_phase = PH_SCAN; n_st = S_FETCH;
                    end
                end else begin
                    n_st = S_FETCH;
                    if (r_rlast) begin
                        n_phase = PH_EAT;
                    end else if (r_minx) begin
                        if (r_eaten != '0) n_eaten = r_eaten - 1'b1;
                        push = 1'b1; n_phase = PH_EAT;
                    end else begin
                        n_phase = PH_FIRST;
                    end
                end
            end
            S_NUL0: begin
                push = 1'b1; p_data = NUL_CH;
                if (r_eaten == '0) begin
                    n_phase = PH_SCAN; n_st = S_FETCH;
                end else begin
                    n_st = S_NULS;
                end
            end
            S_NULS: begin
                push = 1'b1;
                if (r_eaten > LEN_W'(1)) begin
                    p_data = SLASH_CH; n_eaten = r_eaten - 1'b1;
                end else begin
                    p_data = NUL_CH; n_phase = PH_SCAN; n_st = S_FETCH;
                end
            end
            S_SHORT: begin
                if (i_safe) n_serr = 1'b1;
                push = 1'b1; p_data = '0; p_bv = 1'b0; p_st = ST_SHORT; n_st = S_MM;
            end
            S_MM: begin
                sb_re = 1'b1; sb_raddr = '0; n_st = S_MM2;
            end
            S_MM2: begin
                push = 1'b1; p_data = r_sb_rd;
                if (r_ep <= PTR_W'(1)) begin
                    n_rp = '0; n_ep = '0;
                end else begin
                    n_rp = PTR_W'(1);
                end
                n_phase = PH_SCAN; n_st = S_FETCH;
            end
            S_OVF: begin
                push = 1'b1; p_data = '0; p_bv = 1'b0; p_st = ST_OVERFLOW;
                n_k = '0; n_st = S_OV_RD;
            end
            S_OV_RD: begin
                sb_re = 1'b1; sb_raddr = r_k[SAVE_AW-1:0]; n_st = S_OV_OUT;
            end
            S_OV_OUT: begin
                push = 1'b1; p_data = r_sb_rd; n_k = r_k + 1'b1;
                n_st = (r_k == PTR_W'(SAVE_DEPTH - 1)) ? S_OV_C : S_OV_RD;
            end
            S_OV_C: begin
                push = 1'b1; p_data = r_fresh; n_pass = 1'b1;
                n_rp = '0; n_ep = '0; n_phase = PH_SCAN; n_st = S_END;
            end
            S_EOFST: begin
                push = 1'b1; p_data = '0; p_bv = 1'b0; p_st = ST_DONE; n_st = S_CLR;
            end
            S_CLR: begin
                n_rp = '0; n_ep = '0; n_mp = '0; n_phase = PH_SCAN; n_pend = '0;
                n_eaten = '0; n_nul = 1'b0; n_pass = 1'b0; n_repl = '0; n_serr = 1'b0;
                n_st = S_END;
            end
            S_END: begin
                flush = 1'b1; n_st = S_IDLE;
            end
            default: begin
                n_st = S_IDLE;
            end
        endcase
    end

    // Counter and flag fields follow the values as they stand once this step is done.
    assign o_req.push       = push;
    assign o_req.flush      = flush;
    assign o_req.res.data   = p_data;
    assign o_req.res.bvalid = p_bv;
    assign o_req.res.status = p_st;
    assign o_req.res.count  = n_repl;
    assign o_req.res.err    = n_serr;

    assign adv    = !(push && !i_ack.can_push) && !(flush && !i_ack.flush_done);
    assign o_idle = (r_st == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (sp_we) m_search[pat_waddr]  <= i_byte;
            if (rp_we) m_replace[pat_waddr] <= i_byte;
            if (sb_we) m_save[sb_waddr]     <= sb_wdata;
            if (sp_re) r_sp_rd <= m_search[sp_raddr];
            if (rp_re) r_rp_rd <= m_replace[rp_raddr];
            if (sb_re) r_sb_rd <= m_save[sb_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_phase <= PH_SCAN; r_rp <= '0; r_ep <= '0; r_mp <= '0;
            r_pend <= '0; r_eaten <= '0; r_nul <= 1'b0; r_pass <= 1'b0; r_serr <= 1'b0;
            r_repl <= '0; r_have <= 1'b0; r_eof <= 1'b0; r_saved <= 1'b0;
            r_rlast <= 1'b0; r_minx <= 1'b0; r_k <= '0; r_cnt <= '0; r_dst <= '0;
        end else if (adv) begin
            r_st <= n_st; r_phase <= n_phase; r_rp <= n_rp; r_ep <= n_ep; r_mp <= n_mp;
            r_pend <= n_pend; r_eaten <= n_eaten; r_nul <= n_nul; r_pass <= n_pass;
            r_serr <= n_serr; r_repl <= n_repl; r_have <= n_have; r_eof <= n_eof;
            r_saved <= n_saved; r_rlast <= n_rlast; r_minx <= n_minx; r_k <= n_k;
            r_cnt <= n_cnt; r_dst <= n_dst;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_fresh <= n_fresh;
            r_spcur <= n_spcur;
        end
    end

endmodule
